// File: rtl/least_loaded_worker_sorter_macros.svh
// Assertion helpers for the least-loaded worker sorter.
`ifndef LEAST_LOADED_WORKER_SORTER_MACROS_SVH
`define LEAST_LOADED_WORKER_SORTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLWS_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("llws: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLWS_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("llws: next-cycle check failed");

`endif

// File: rtl/llws_pkg.sv
`default_nettype none

package llws_pkg;

    localparam int NUM_WORKERS_DEF = 16;
    localparam int LOAD_BITS_DEF   = 16;

    localparam int ID_W     = 4;
    localparam int AMOUNT_W = 16;
    localparam int LOAD_W   = 16;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef struct packed {
        logic                func;
        logic [ID_W-1:0]     worker_id;
        logic [AMOUNT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   least_loaded_worker;
        logic [LOAD_W-1:0] least_load;
        logic [LOAD_W-1:0] new_load;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic accept;
        logic take_slot;
        logic take_load;
        logic step_up;
        logic probe_dn;
        logic step_dn;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic id_ok;
        logic up_go;
        logic dn_go;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/llws_ram.sv
`default_nettype none

module llws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/llws_ctrl.sv
`default_nettype none

module llws_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire llws_pkg::dp_sts_t sts,
    output llws_pkg::dp_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);

    import llws_pkg::*;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SLOT  = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_PROBE = 8'b0001_0000,
        S_UP    = 8'b0010_0000,
        S_DN    = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.id_ok ? S_SLOT : S_RESP;
                end
            end
            S_SLOT:
            begin
                cmd.take_slot = 1'b1;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.take_load = 1'b1;
                state_next    = S_PROBE;
            end
            S_PROBE:
            begin
                // Moving toward the tail takes precedence over the head.
                if (sts.up_go)
                begin
                    cmd.step_up = 1'b1;
                    state_next  = S_UP;
                end
                else
                begin
                    cmd.probe_dn = 1'b1;
                    state_next   = S_DN;
                end
            end
            S_UP:
            begin
                if (sts.up_go)
                begin
                    cmd.step_up = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_DN:
            begin
                if (sts.dn_go)
                begin
                    cmd.step_dn = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

`default_nettype wire

// File: rtl/llws_dp.sv
`default_nettype none

module llws_dp #(
    parameter int NUM_WORKERS = llws_pkg::NUM_WORKERS_DEF,
    parameter int LOAD_BITS   = llws_pkg::LOAD_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire llws_pkg::in_item_t item,
    input  wire llws_pkg::dp_cmd_t  cmd,
    output llws_pkg::dp_sts_t       sts,
    output llws_pkg::out_item_t     result
);

    import llws_pkg::*;

    localparam int IDX_W = $clog2(NUM_WORKERS);
    localparam int ENT_W = IDX_W + LOAD_BITS;
    localparam int SUM_W = ((LOAD_BITS > AMOUNT_W) ? LOAD_BITS : AMOUNT_W) + 1;
    localparam logic [IDX_W-1:0] LAST     = IDX_W'(NUM_WORKERS - 1);
    localparam logic [SUM_W-1:0] LOAD_MAX = SUM_W'({LOAD_BITS{1'b1}});

    logic [IDX_W-1:0]     w_reg;
    logic                 func_reg;
    logic [AMOUNT_W-1:0]  amount_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [LOAD_BITS-1:0] cnt_reg;
    logic [LOAD_BITS-1:0] newload_reg;
    logic [LOAD_BITS-1:0] newload_next;
    logic [IDX_W-1:0]     clr_idx_reg;
    logic [IDX_W-1:0]     head_w_reg;
    logic [LOAD_BITS-1:0] head_ld_reg;

    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr;
    logic [ENT_W-1:0] ord_wdata;
    logic [IDX_W-1:0] ord_raddr;
    logic [ENT_W-1:0] ord_rdata;
    logic             slot_we;
    logic [IDX_W-1:0] slot_waddr;
    logic [IDX_W-1:0] slot_wdata;
    logic [IDX_W-1:0] slot_raddr;
    logic [IDX_W-1:0] slot_rdata;

    logic [IDX_W-1:0]     rd_w;
    logic [LOAD_BITS-1:0] rd_ld;
    logic [8:0]           id_wide;
    logic [8:0]           head_w_wide;
    logic [31:0]          head_ld_wide;
    logic [31:0]          newload_wide;
    logic [SUM_W-1:0]     cur_ext;
    logic [SUM_W-1:0]     amt_ext;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     diff;
    logic [LOAD_BITS-1:0] sat_load;

    // Slot to {worker, load}: the sorted order with each load kept beside it.
    llws_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_WORKERS)
    ) u_ord_ram (
        .clk  (clk),
        .we   (ord_we),
        .waddr(ord_waddr),
        .wdata(ord_wdata),
        .raddr(ord_raddr),
        .rdata(ord_rdata)
    );

    // Worker to slot.
    llws_ram #(
        .WIDTH(IDX_W),
        .DEPTH(NUM_WORKERS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .raddr(slot_raddr),
        .rdata(slot_rdata)
    );

    assign rd_w    = ord_rdata[ENT_W-1:LOAD_BITS];
    assign rd_ld   = ord_rdata[LOAD_BITS-1:0];
    assign id_wide = 9'(item.worker_id);

    // Saturating update of the load that was just read from the worker's slot.
    assign cur_ext = SUM_W'(rd_ld);
    assign amt_ext = SUM_W'(amount_reg);
    assign sum     = cur_ext + amt_ext;
    assign diff    = cur_ext - amt_ext;

    always_comb
    begin
        if (func_reg == FUNC_REMOVE)
        begin
            sat_load = (amt_ext > cur_ext) ? '0 : diff[LOAD_BITS-1:0];
        end
        else
        begin
            sat_load = (sum > LOAD_MAX) ? LOAD_MAX[LOAD_BITS-1:0] : sum[LOAD_BITS-1:0];
        end
    end

    // Memory port steering.
    always_comb
    begin
        ord_we     = 1'b0;
        ord_waddr  = pos_reg;
        ord_wdata  = ord_rdata;
        ord_raddr  = pos_reg;
        slot_we    = 1'b0;
        slot_waddr = rd_w;
        slot_wdata = pos_reg;
        slot_raddr = id_wide[IDX_W-1:0];
        if (cmd.clr)
        begin
            ord_we     = 1'b1;
            ord_waddr  = clr_idx_reg;
            ord_wdata  = {clr_idx_reg, {LOAD_BITS{1'b0}}};
            slot_we    = 1'b1;
            slot_waddr = clr_idx_reg;
            slot_wdata = clr_idx_reg;
        end
        else if (cmd.take_slot)
        begin
            ord_raddr = slot_rdata;
        end
        else if (cmd.take_load)
        begin
            ord_raddr = pos_reg + IDX_W'(1);
        end
        else if (cmd.step_up)
        begin
            // The neighbor drops into the current slot.
            ord_we    = 1'b1;
            slot_we   = 1'b1;
            ord_raddr = pos_reg + IDX_W'(2);
        end
        else if (cmd.probe_dn)
        begin
            ord_raddr = pos_reg - IDX_W'(1);
        end
        else if (cmd.step_dn)
        begin
            ord_we    = 1'b1;
            slot_we   = 1'b1;
            ord_raddr = pos_reg - IDX_W'(2);
        end
        else if (cmd.finish)
        begin
            ord_we     = 1'b1;
            ord_wdata  = {w_reg, cnt_reg};
            slot_we    = 1'b1;
            slot_waddr = w_reg;
        end
    end

    always_comb
    begin
        newload_next = newload_reg;
        if (cmd.accept)
        begin
            newload_next = '0;
        end
        else if (cmd.take_load)
        begin
            newload_next = sat_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            w_reg      <= id_wide[IDX_W-1:0];
            func_reg   <= item.func;
            amount_reg <= item.amount;
        end
        if (cmd.take_slot)
        begin
            pos_reg <= slot_rdata;
        end
        else if (cmd.step_up)
        begin
            pos_reg <= pos_reg + IDX_W'(1);
        end
        else if (cmd.step_dn)
        begin
            pos_reg <= pos_reg - IDX_W'(1);
        end
        if (cmd.take_load)
        begin
            cnt_reg <= sat_load;
        end
        newload_reg <= newload_next;
    end

    // The head entry is mirrored so that the result needs no memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            head_w_reg  <= '0;
            head_ld_reg <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (ord_we && (ord_waddr == '0))
            begin
                head_w_reg  <= ord_wdata[ENT_W-1:LOAD_BITS];
                head_ld_reg <= ord_wdata[LOAD_BITS-1:0];
            end
        end
    end

    assign sts.clr_last = (clr_idx_reg == LAST);
    assign sts.id_ok    = (32'(item.worker_id) < 32'(NUM_WORKERS));
    assign sts.up_go    = (pos_reg != LAST) && (cnt_reg > rd_ld);
    assign sts.dn_go    = (pos_reg != '0) && (cnt_reg < rd_ld);

    assign head_w_wide  = 9'(head_w_reg);
    assign head_ld_wide = 32'(head_ld_reg);
    assign newload_wide = 32'(newload_reg);

    assign result.least_loaded_worker = head_w_wide[ID_W-1:0];
    assign result.least_load          = head_ld_wide[LOAD_W-1:0];
    assign result.new_load            = newload_wide[LOAD_W-1:0];

endmodule

`default_nettype wire

// File: rtl/least_loaded_worker_sorter.sv
// Channel   Ports                        Transfer condition
// -------   --------------------------   ------------------------------------
// input     start, busy, item            rising edge with start high, busy low
// result    done, result                 every rising edge that ends a done cycle
//
// An in-range item goes through the slot lookup, the load update and a probe
// of the upper neighbor, then shifts its worker toward the tail, or reads the
// lower neighbor and shifts it toward the head or leaves it in place.
// An out-of-range worker gives its result in the cycle after the transfer. Busy
// drops in the cycle after done. The shift loop moves one neighbor per cycle
// through the single read port of the sorted-order memory.
// After reset a clearing pass loads the identity order and zero loads;
// busy stays high until it ends.
// Done is high for exactly one cycle per item and the receiver cannot stall.

`default_nettype none

module least_loaded_worker_sorter #(
    parameter int NUM_WORKERS = llws_pkg::NUM_WORKERS_DEF,
    parameter int LOAD_BITS   = llws_pkg::LOAD_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire llws_pkg::in_item_t item,
    output logic                    done,
    output llws_pkg::out_item_t     result
);

    import llws_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The controller sequences the lookup, the saturating update, the
    // neighbor shifts in one direction, and the final placement.
    llws_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .sts  (sts),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    // The datapath holds the slot and worker memories, the position being
    // moved, and a mirror of the head slot that feeds the result.
    llws_dp #(
        .NUM_WORKERS(NUM_WORKERS),
        .LOAD_BITS  (LOAD_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .sts   (sts),
        .result(result)
    );

endmodule

`default_nettype wire

// File: rtl/llws_chk.sv
`default_nettype none

`include "least_loaded_worker_sorter_macros.svh"

module llws_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // A result only appears while an item is in flight.
    `LLWS_ASSERT_IMP(a_done_while_busy, clk, rst_n, done, busy)
    // Each item yields a single result cycle.
    `LLWS_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    // The block is ready again right after a result.
    `LLWS_ASSERT_NXT(a_ready_after_done, clk, rst_n, done, !busy)
    // An accepted item keeps the block busy in the next cycle.
    `LLWS_ASSERT_NXT(a_busy_after_take, clk, rst_n, start && !busy, busy)

endmodule

bind least_loaded_worker_sorter llws_chk u_llws_chk (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (done)
);

`default_nettype wire

// File: dv/least_loaded_worker_sorter_tb.sv
`timescale 1ns / 1ps

module least_loaded_worker_sorter_tb;

    import llws_pkg::*;

    localparam int NUM_WORKERS = NUM_WORKERS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 30;
    localparam int RANDOM_ITEMS = 1800;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  item = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    // Shadow copy of the sorted worker array kept by the predictor.
    logic [ID_W-1:0]   model_order [NUM_WORKERS];
    logic [ID_W-1:0]   model_slot [NUM_WORKERS];
    logic [LOAD_W-1:0] model_load [NUM_WORKERS];

    // Expected results, oldest at the front.
    out_item_t expected_results [$];
    out_item_t oldest_expected;

    int items_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int saturations = 0;
    int end_moves = 0;
    int idle_cycles = 0;

    least_loaded_worker_sorter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The shadow array starts in the same state the clearing pass leaves
    // behind: worker i in slot i, every load at zero.
    initial
    begin
        for (int i = 0; i < NUM_WORKERS; i++)
        begin
            model_order[i] = i[ID_W-1:0];
            model_slot[i]  = i[ID_W-1:0];
            model_load[i]  = '0;
        end
    end

    // Applies one item to the shadow array and returns the result it causes.
    // The load saturates at both ends; the worker then bubbles toward the
    // tail while it is strictly heavier than its upper neighbor, or else
    // toward the head while it is strictly lighter than its lower neighbor.
    function automatic out_item_t predict_least_loaded(input in_item_t it);
        logic [LOAD_W:0]   sum;
        logic [LOAD_W-1:0] cnt;
        out_item_t         r;
        int                w;
        int                pos;
        int                first_pos;
        r = '0;
        if (int'(it.worker_id) < NUM_WORKERS)
        begin
            w = int'(it.worker_id);
            if (it.func == FUNC_ADD)
            begin
                sum = {1'b0, model_load[w]} + {1'b0, it.amount};
                if (sum[LOAD_W])
                begin
                    model_load[w] = '1;
                    saturations++;
                end
                else
                begin
                    model_load[w] = sum[LOAD_W-1:0];
                end
            end
            else if (it.amount > model_load[w])
            begin
                model_load[w] = '0;
                saturations++;
            end
            else
            begin
                model_load[w] = model_load[w] - it.amount;
            end

            cnt = model_load[w];
            pos = int'(model_slot[w]);
            first_pos = pos;
            if (pos + 1 < NUM_WORKERS && cnt > model_load[model_order[pos + 1]])
            begin
                while (pos + 1 < NUM_WORKERS && cnt > model_load[model_order[pos + 1]])
                begin
                    model_order[pos] = model_order[pos + 1];
                    model_slot[model_order[pos]] = pos[ID_W-1:0];
                    pos++;
                end
                model_order[pos] = w[ID_W-1:0];
                model_slot[w] = pos[ID_W-1:0];
            end
            else if (pos > 0 && cnt < model_load[model_order[pos - 1]])
            begin
                while (pos > 0 && cnt < model_load[model_order[pos - 1]])
                begin
                    model_order[pos] = model_order[pos - 1];
                    model_slot[model_order[pos]] = pos[ID_W-1:0];
                    pos--;
                end
                model_order[pos] = w[ID_W-1:0];
                model_slot[w] = pos[ID_W-1:0];
            end
            if (pos != first_pos && (pos == 0 || pos == NUM_WORKERS - 1))
                end_moves++;
            r.new_load = cnt;
        end
        r.least_loaded_worker = model_order[0];
        r.least_load = model_load[model_order[0]];
        return r;
    endfunction

    function automatic in_item_t make_item(input logic func, input int id,
                                           input logic [AMOUNT_W-1:0] amount);
        in_item_t it;
        it.func = func;
        it.worker_id = id[ID_W-1:0];
        it.amount = amount;
        return it;
    endfunction

    // Presents one item and holds it until the block takes the transfer.
    // Start is left high so that a following item with no gap goes out
    // back to back; only a gap or a drain lowers it.
    task automatic send_item(input in_item_t it, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_results.push_back(predict_least_loaded(it));
        items_sent++;
    endtask

    // Stops sending and waits until every outstanding result has come back.
    // At least one edge passes so that start is never lowered and raised in
    // the same time step.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input out_item_t want,
                                   input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected worker %0d load %0d new %0d, got worker %0d load %0d new %0d",
                     $realtime, what, want.least_loaded_worker, want.least_load,
                     want.new_load, got.least_loaded_worker, got.least_load, got.new_load);
    endtask

    // Every result is on the ports for exactly one cycle, so it is sampled
    // at the edge that ends that cycle and compared with the oldest
    // expectation field by field.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", '0, result);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                results_checked++;
                if (result.least_loaded_worker !== oldest_expected.least_loaded_worker
                    || result.least_load !== oldest_expected.least_load
                    || result.new_load !== oldest_expected.new_load)
                    report_mismatch("result mismatch", oldest_expected, result);
            end
        end
    end

    // The watchdog counts cycles with no transfer on either side. The
    // slowest correct gap is the clearing pass after reset, or a sender gap
    // plus a full shift across the array, both far below the limit.
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("[least_loaded_worker_sorter] ERROR");
        $finish;
    end

    // Zero amounts only query; the result must show the head worker and an
    // unchanged load, with either operation.
    task automatic test_idle_queries();
        send_item(make_item(FUNC_ADD, 0, '0), 1'b0);
        send_item(make_item(FUNC_REMOVE, NUM_WORKERS - 1, '0), 1'b0);
    endtask

    // A worker moves all the way to the tail slot, a tie stops a move one
    // slot short, and the head worker is updated where it has no lower
    // neighbor.
    task automatic test_moves_to_ends();
        send_item(make_item(FUNC_ADD, 0, 16'd1), 1'b0);
        send_item(make_item(FUNC_ADD, 1, 16'd1), 1'b0);
        send_item(make_item(FUNC_REMOVE, 2, 16'd5), 1'b0);
        send_item(make_item(FUNC_ADD, 1, 16'd3), 1'b0);
        send_item(make_item(FUNC_REMOVE, 1, 16'd3), 1'b1);
    endtask

    // Add overflow clamps at the largest count, remove underflow at zero.
    task automatic test_saturation();
        send_item(make_item(FUNC_ADD, 3, 16'hFFFF), 1'b0);
        send_item(make_item(FUNC_ADD, 3, 16'd100), 1'b1);
        send_item(make_item(FUNC_REMOVE, 3, 16'hFFFF), 1'b0);
        send_item(make_item(FUNC_REMOVE, 3, 16'd1), 1'b0);
    endtask

    // Alternating bit patterns on the id and the amount toggle every bit.
    task automatic test_field_extremes();
        send_item(make_item(FUNC_ADD, 15, 16'hFFFF), 1'b0);
        send_item(make_item(FUNC_REMOVE, 15, 16'h8000), 1'b0);
        send_item(make_item(FUNC_ADD, 10, 16'hAAAA), 1'b1);
        send_item(make_item(FUNC_ADD, 5, 16'h5555), 1'b0);
        send_item(make_item(FUNC_REMOVE, 10, 16'hFFFF), 1'b0);
    endtask

    // Mostly small amounts so that loads stay close together and ties and
    // long shifts are common; the rest are full-range and extreme amounts
    // that saturate and send workers between the ends. Stretches of back to
    // back transfers alternate with random gaps, and now and then the
    // sender drains the block completely.
    task automatic test_random_traffic(input int count);
        in_item_t it;
        int       roll;
        bit       back_to_back;
        back_to_back = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            if (n % 400 == 399)
                wait_for_results();
            roll = $urandom_range(0, 99);
            it.func = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_REMOVE;
            it.worker_id = ID_W'($urandom_range(0, NUM_WORKERS - 1));
            if (roll < 65)
                it.amount = AMOUNT_W'($urandom_range(0, 6));
            else if (roll < 85)
                it.amount = AMOUNT_W'($urandom);
            else if (roll < 93)
                it.amount = '1;
            else
                it.amount = $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
            send_item(it, back_to_back);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_queries();
        test_moves_to_ends();
        test_saturation();
        test_field_extremes();
        wait_for_results();
        test_random_traffic(RANDOM_ITEMS);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        mismatch_count += expected_results.size();

        $display("Summary: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatch_count);
        $display("Summary: %0d saturating updates, %0d moves ending in the head or tail slot",
                 saturations, end_moves);
        if (mismatch_count == 0)
            $display("[least_loaded_worker_sorter] OK");
        else
            $display("[least_loaded_worker_sorter] ERROR");
        $finish;
    end

endmodule
